@@ sv/lbr_pkg.sv @@
package lbr_pkg;

    localparam int TICK_MS        = 20;
    localparam int PHASE_BITS     = 16;
    localparam int SINE_DEPTH     = 256;
    localparam int SINE_IDX_W     = $clog2(SINE_DEPTH);
    localparam int SINE_ADDR_W    = SINE_IDX_W + 1;
    localparam int SINE_W         = 16;
    localparam int BREATH_W       = SINE_W + 1;
    localparam int COLOR_W        = 8;
    localparam int MODE_W         = 2;
    localparam int PERIOD_W       = 16;
    localparam int DEFAULT_PERIOD = 1000;
    localparam int REG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    // Dividend is TICK_MS * 2^PHASE_BITS plus half the period.
    localparam int DIV_W    = PHASE_BITS + $clog2(TICK_MS + 1);
    localparam int SCALED_W = BREATH_W - 1 + COLOR_W;
    localparam int FRAC_W   = PHASE_BITS + 1;
    localparam int HUE6_W   = PHASE_BITS + 3;
    localparam int MUL_A_W  = SCALED_W;
    localparam int MUL_B_W  = FRAC_W;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF     = 2'd0,
        MODE_SOLID   = 2'd1,
        MODE_BREATH  = 2'd2,
        MODE_RAINBOW = 2'd3
    } t_mode;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MODE   = 3'd0,
        REG_RED    = 3'd1,
        REG_GREEN  = 3'd2,
        REG_BLUE   = 3'd3,
        REG_PEAK   = 3'd4,
        REG_PERIOD = 3'd5
    } t_reg_idx;

    typedef struct packed {
        t_mode                mode;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
        logic [COLOR_W-1:0]   peak;
        logic [PERIOD_W-1:0]  period;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [PERIOD_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_W-1:0]     quotient;
    } t_div_rsp;

    typedef struct packed {
        logic                 valid;
        t_mode                mode;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
    } t_res;

    // Quarter-wave sine entry k in unsigned Q15, from a Q30 Taylor series through x^15.
    function automatic logic [SINE_W-1:0] f_sine(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        r;
        logic signed [63:0] sum;
        x    = (64'(k) * HALF_PI_Q30) / SINE_DEPTH;
        term = x;
        sum  = signed'(x);
        for (int n = 1; n <= 7; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                default: term = term / 64'd210;
            endcase
            if ((n & 1) == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        r = (unsigned'(sum) + 64'd16384) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return r[SINE_W-1:0];
    endfunction

    // Exact v / 255 for any v up to 255 * 255.
    function automatic logic [COLOR_W-1:0] f_div255(input logic [2*COLOR_W-1:0] v);
        logic [2*COLOR_W:0] s;
        s = {1'b0, v} + (2*COLOR_W+1)'(1) + (2*COLOR_W+1)'(v >> COLOR_W);
        return s[2*COLOR_W-1:COLOR_W];
    endfunction

endpackage

@@ sv/lbr_if.sv @@
interface lbr_tick_if;
    logic valid;
    logic ready;
    logic tick;
    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface lbr_rgb_if;
    logic                       valid;
    logic                       ready;
    logic [lbr_pkg::COLOR_W-1:0] red;
    logic [lbr_pkg::COLOR_W-1:0] green;
    logic [lbr_pkg::COLOR_W-1:0] blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface lbr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lbr_pkg::REG_IDX_W-1:0]  index;
    logic [lbr_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/led_breath_rainbow_effect_core.sv @@
// Breathing and rainbow color generator for one RGB LED.
// i_in carries one tick word per elapsed effect interval. o_out returns at most
// one red/green/blue word per tick: none when the tick bit is low or the mode is
// off, the base color in solid mode, a sine-breathing scaled color in breathing
// mode and a full-saturation hue sweep at the breathing brightness in rainbow mode.
// i_cfg writes registers 0..5 (mode, red, green, blue, peak, period); it is
// always ready, and any write to a listed register restarts the phase at zero.
// A breathing or rainbow tick runs the 21-step restoring divider that forms the
// phase step, followed by a few passes through the one shared multiplier; a
// solid tick takes the base color as its result. i_in is not ready again until
// the item has handed its result on; a tick without a result leaves the input
// ready, so such ticks are taken every cycle. The result sits in an output
// register; while the receiver stalls, the sequencer keeps the next result
// waiting and the input stays low on ready. Reset clears the phase and sets
// every register to zero except the period, which returns to 1000 ms; the block
// is ready the cycle after reset.
module led_breath_rainbow_effect_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lbr_tick_if.sink    i_in,
    lbr_rgb_if.source   o_out,
    lbr_cfg_if.sink     i_cfg
);
    import lbr_pkg::*;

    t_cfg               r_cfg;
    logic               r_out_valid;
    logic [COLOR_W-1:0] r_out_red;
    logic [COLOR_W-1:0] r_out_green;
    logic [COLOR_W-1:0] r_out_blue;
    logic               w_cfg_wr;
    logic               w_phase_clr;
    logic               w_idle;
    logic               w_res_free;
    t_res               w_res;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= MODE_OFF;
            r_cfg.red    <= '0;
            r_cfg.green  <= '0;
            r_cfg.blue   <= '0;
            r_cfg.peak   <= '0;
            r_cfg.period <= PERIOD_W'(DEFAULT_PERIOD);
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_MODE:   r_cfg.mode   <= t_mode'(i_cfg.data[MODE_W-1:0]);
                REG_RED:    r_cfg.red    <= i_cfg.data[COLOR_W-1:0];
                REG_GREEN:  r_cfg.green  <= i_cfg.data[COLOR_W-1:0];
                REG_BLUE:   r_cfg.blue   <= i_cfg.data[COLOR_W-1:0];
                REG_PEAK:   r_cfg.peak   <= i_cfg.data[COLOR_W-1:0];
                REG_PERIOD: r_cfg.period <= i_cfg.data[PERIOD_W-1:0];
                default:    r_cfg.mode   <= r_cfg.mode;
            endcase
        end
    end

    // Only writes to listed registers restart the phase.
    assign w_phase_clr = w_cfg_wr && (i_cfg.index <= REG_IDX_W'(REG_PERIOD));

    assign i_in.ready = w_idle;
    assign w_res_free = !r_out_valid || o_out.ready;

    lbr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in.valid && i_in.ready),
        .i_tick      (i_in.tick),
        .i_cfg       (r_cfg),
        .i_phase_clr (w_phase_clr),
        .i_res_free  (w_res_free),
        .o_idle      (w_idle),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_free) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_free && w_res.valid) begin
            r_out_red   <= w_res.red;
            r_out_green <= w_res.green;
            r_out_blue  <= w_res.blue;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.red   = r_out_red;
    assign o_out.green = r_out_green;
    assign o_out.blue  = r_out_blue;

`ifndef SYNTHESIS
    // A word that produces no result leaves the block ready again at once.
    a_no_result_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (!i_in.tick || r_cfg.mode == MODE_OFF)) |=> i_in.ready)
        else $error("block not ready after a word without result");

    // A finished result waits in the sequencer while the output register is full.
    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.valid && !w_res_free) |=> w_res.valid)
        else $error("result dropped while output stalled");

    // A rainbow color always has one channel at zero.
    a_rainbow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.valid && w_res.mode == MODE_RAINBOW) |->
        (w_res.red == '0 || w_res.green == '0 || w_res.blue == '0))
        else $error("rainbow result without a dark channel");
`endif

endmodule

@@ sv/lbr_div.sv @@
module lbr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbr_pkg::t_div_req i_req,
    output lbr_pkg::t_div_rsp o_rsp
);
    import lbr_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_dsr;
    logic [DIV_W-1:0]    r_quo;
    logic [PERIOD_W:0]   w_trial;
    logic [PERIOD_W:0]   w_diff;
    logic                w_ge;

    // Restoring division, one quotient bit per cycle. The dividend shifts out of
    // the top of r_quo while quotient bits shift in at the bottom.
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dsr};
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[PERIOD_W-1:0] : w_trial[PERIOD_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ sv/lbr_seq.sv @@
module lbr_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_tick,
    input  lbr_pkg::t_cfg i_cfg,
    input  logic          i_phase_clr,
    input  logic          i_res_free,
    output logic          o_idle,
    output lbr_pkg::t_res o_res
);
    import lbr_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_DIV  = 11'b000_0000_0010,
        S_LUT  = 11'b000_0000_0100,
        S_MBR  = 11'b000_0000_1000,
        S_SCL  = 11'b000_0001_0000,
        S_MCH  = 11'b000_0010_0000,
        S_DCH  = 11'b000_0100_0000,
        S_FRC  = 11'b000_1000_0000,
        S_MX   = 11'b001_0000_0000,
        S_XST  = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } t_state;

    localparam logic [BREATH_W-1:0] BREATH_MID = BREATH_W'(1) << (SINE_W - 1);
    localparam logic [FRAC_W-1:0]   FULL_TURN  = FRAC_W'(1) << PHASE_BITS;

    t_state                r_state;
    t_state                n_state;
    t_mode                 r_mode;
    logic [PHASE_BITS-1:0] r_phase;
    logic [1:0]            r_ch_sel;
    logic [BREATH_W-1:0]   r_breath;
    logic [SCALED_W-1:0]   r_scaled;
    logic [2:0]            r_sector;
    logic [FRAC_W-1:0]     r_frac;
    logic [PROD_W-1:0]     r_prod;
    logic [COLOR_W-1:0]    r_rgb [3];

    logic [SINE_W-1:0]      w_lut [SINE_DEPTH+1];
    logic [1:0]             w_quad;
    logic [SINE_IDX_W-1:0]  w_idx;
    logic [SINE_ADDR_W-1:0] w_addr;
    logic [SINE_W-1:0]      w_sine;
    logic [PERIOD_W-1:0]    w_divisor;
    logic                   w_compute;
    t_div_req               w_div_req;
    t_div_rsp               w_div_rsp;
    logic [MUL_A_W-1:0]     w_mul_a;
    logic [MUL_B_W-1:0]     w_mul_b;
    logic [COLOR_W-1:0]     w_color;
    logic [COLOR_W-1:0]     w_br;
    logic [COLOR_W-1:0]     w_x;
    logic [HUE6_W-1:0]      w_hue6;

    for (genvar k = 0; k <= SINE_DEPTH; k++) begin : g_lut
        localparam logic [SINE_W-1:0] SINE_K = f_sine(k);
        assign w_lut[k] = SINE_K;
    end

    // Quarter-wave lookup: odd quadrants mirror the index, the upper half negates.
    assign w_quad = r_phase[PHASE_BITS-1 -: 2];
    assign w_idx  = r_phase[PHASE_BITS-3 -: SINE_IDX_W];
    assign w_addr = w_quad[0] ? (SINE_ADDR_W'(SINE_DEPTH) - SINE_ADDR_W'(w_idx))
                              : SINE_ADDR_W'(w_idx);
    assign w_sine = w_lut[w_addr];

    assign w_divisor = (i_cfg.period == '0) ? PERIOD_W'(DEFAULT_PERIOD) : i_cfg.period;
    assign w_compute = (r_state == S_IDLE) && i_start && i_tick &&
                       (i_cfg.mode == MODE_BREATH || i_cfg.mode == MODE_RAINBOW);

    assign w_div_req.start    = w_compute;
    assign w_div_req.divisor  = w_divisor;
    assign w_div_req.dividend = (DIV_W'(TICK_MS) << PHASE_BITS) + DIV_W'(w_divisor >> 1);

    lbr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // The secondary channel drops both the Q16 breath fraction and the hue fraction.
    assign w_br   = r_scaled[SCALED_W-1 -: COLOR_W];
    assign w_x    = r_prod[BREATH_W-1+PHASE_BITS +: COLOR_W];
    assign w_hue6 = r_prod[HUE6_W-1:0];

    always_comb begin
        case (r_ch_sel)
            2'd0:    w_color = i_cfg.red;
            2'd1:    w_color = i_cfg.green;
            default: w_color = i_cfg.blue;
        endcase
    end

    // Operand select for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_MBR: begin
                w_mul_a = MUL_A_W'(i_cfg.peak);
                w_mul_b = MUL_B_W'(r_breath);
            end
            S_SCL: begin
                w_mul_a = MUL_A_W'(r_phase);
                w_mul_b = MUL_B_W'(6);
            end
            S_MCH: begin
                w_mul_a = MUL_A_W'(w_color);
                w_mul_b = MUL_B_W'(w_br);
            end
            S_MX: begin
                w_mul_a = r_scaled;
                w_mul_b = r_frac;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_compute) begin
                    n_state = S_DIV;
                end else if (i_start && i_tick && i_cfg.mode == MODE_SOLID) begin
                    n_state = S_OUT;
                end
            end
            S_DIV:   n_state = w_div_rsp.done ? S_LUT : S_DIV;
            S_LUT:   n_state = S_MBR;
            S_MBR:   n_state = S_SCL;
            S_SCL:   n_state = (r_mode == MODE_RAINBOW) ? S_FRC : S_MCH;
            S_MCH:   n_state = S_DCH;
            S_DCH:   n_state = (r_ch_sel == 2'd2) ? S_OUT : S_MCH;
            S_FRC:   n_state = S_MX;
            S_MX:    n_state = S_XST;
            S_XST:   n_state = S_OUT;
            S_OUT:   n_state = i_res_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_OFF;
            r_phase  <= '0;
            r_ch_sel <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_start) begin
                r_mode <= i_cfg.mode;
            end
            if (i_phase_clr) begin
                r_phase <= '0;
            end else if (r_state == S_DIV && w_div_rsp.done) begin
                r_phase <= r_phase + w_div_rsp.quotient[PHASE_BITS-1:0];
            end
            if (r_state == S_SCL) begin
                r_ch_sel <= '0;
            end else if (r_state == S_DCH) begin
                r_ch_sel <= r_ch_sel + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (r_state == S_IDLE && i_start) begin
            r_rgb[0] <= i_cfg.red;
            r_rgb[1] <= i_cfg.green;
            r_rgb[2] <= i_cfg.blue;
        end
        if (r_state == S_LUT) begin
            r_breath <= w_quad[1] ? (BREATH_MID - BREATH_W'(w_sine))
                                  : (BREATH_MID + BREATH_W'(w_sine));
        end
        if (r_state == S_SCL) begin
            r_scaled <= r_prod[SCALED_W-1:0];
        end
        if (r_state == S_DCH) begin
            r_rgb[r_ch_sel] <= f_div255(r_prod[2*COLOR_W-1:0]);
        end
        if (r_state == S_FRC) begin
            r_sector <= w_hue6[HUE6_W-1 -: 3];
            r_frac   <= w_hue6[PHASE_BITS] ? (FULL_TURN - FRAC_W'(w_hue6[PHASE_BITS-1:0]))
                                           : FRAC_W'(w_hue6[PHASE_BITS-1:0]);
        end
        if (r_state == S_XST) begin
            // Hue sectors run red, yellow, green, cyan, blue, magenta.
            case (r_sector)
                3'd0: begin r_rgb[0] <= w_br; r_rgb[1] <= w_x;  r_rgb[2] <= '0;   end
                3'd1: begin r_rgb[0] <= w_x;  r_rgb[1] <= w_br; r_rgb[2] <= '0;   end
                3'd2: begin r_rgb[0] <= '0;   r_rgb[1] <= w_br; r_rgb[2] <= w_x;  end
                3'd3: begin r_rgb[0] <= '0;   r_rgb[1] <= w_x;  r_rgb[2] <= w_br; end
                3'd4: begin r_rgb[0] <= w_x;  r_rgb[1] <= '0;   r_rgb[2] <= w_br; end
                default: begin r_rgb[0] <= w_br; r_rgb[1] <= '0; r_rgb[2] <= w_x; end
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res.valid = (r_state == S_OUT);
    assign o_res.mode  = r_mode;
    assign o_res.red   = r_rgb[0];
    assign o_res.green = r_rgb[1];
    assign o_res.blue  = r_rgb[2];

endmodule
